>>> hw/rtl/ahcd_pkg.sv
// ----------------------------------------------------------------------------
// ahcd_pkg: shared types, constants and functions
// Beat types, phase and verdict codes, CRC-32 byte step and the rotate.
// ----------------------------------------------------------------------------
package ahcd_pkg;

  localparam int unsigned HeaderBytes  = 18;
  localparam int unsigned RotateBits   = 2;
  localparam int unsigned MagicLen     = 3;
  localparam int unsigned CrcLen       = 14;
  localparam int unsigned OffsetPos    = 6;
  localparam int unsigned CountPos     = 10;
  localparam int unsigned StoredCrcPos = 14;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  localparam logic [7:0] MagicByte0 = 8'h54;
  localparam logic [7:0] MagicByte1 = 8'h43;
  localparam logic [7:0] MagicByte2 = 8'h46;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_BAD_MAGIC = 2'd1,
    VERDICT_BAD_CRC   = 2'd2,
    VERDICT_UNDERFLOW = 2'd3
  } verdict_e;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    kind_e       item_kind;
    verdict_e    verdict;
    logic [31:0] index_position;
    logic [31:0] entry_count;
    logic [7:0]  plain_byte;
    logic        payload_end;
  } out_t;

  // Reflected CRC-32, one byte, eight shift steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] rotate_right(input logic [7:0] b);
    logic [15:0] w;
    w = {b, b} >> (RotateBits % 8);
    return w[7:0];
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = MagicByte0;
      2'd1:    m = MagicByte1;
      2'd2:    m = MagicByte2;
      default: m = 8'd0;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/archive_header_check_and_descramble_top.sv
// ----------------------------------------------------------------------------
// archive_header_check_and_descramble_top: header check and descrambler
// Parses an 18-byte archive header (magic, CRC-32, offset, count), emits one
// verdict beat, then the rotated payload bytes up to the index offset.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------
//  in      | sink      | in_valid_i / in_ready_o   | ahcd_pkg::in_t  in_data_i
//  out     | source    | out_valid_o / out_ready_i | ahcd_pkg::out_t out_data_o
//
//  One byte per cycle sustained while the output is not stalled; an accepted beat
//  passes the input register, then the result register (two register stages).
//  The cycle budget is the 8-step CRC-32 byte update plus one 33-bit compare.
//  Reset (rst_ni low) clears all parser state; parsing starts at header byte 0.
//  Output stall backs up through the input register to in_ready_o.
//  Dropped bytes and all header bytes but the last (the verdict) make no output beat.
//
module archive_header_check_and_descramble_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ahcd_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ahcd_pkg::out_t  out_data_o
);
  import ahcd_pkg::*;

  // input register
  logic        in_v_q;
  in_t         in_q;

  // parser state
  logic [31:0] pos_q,  pos_d;
  logic [31:0] crc_q,  crc_d;
  logic        magic_q, magic_d;
  logic [31:0] off_q,  off_d;
  logic [31:0] cnt_q,  cnt_d;
  logic [31:0] scrc_q, scrc_d;
  phase_e      phase_q, phase_d;

  // result register
  logic        out_v_q;
  out_t        out_q;

  // effective state after an optional restart
  logic [31:0] pos_b, crc_b, off_b, cnt_b, scrc_b;
  logic        magic_b;
  phase_e      phase_b;

  logic        s1_fire;
  logic        res_valid;
  out_t        res;
  logic [7:0]  b;
  logic [1:0]  lane;
  logic [31:0] scrc_fin;
  verdict_e    verdict;
  logic [32:0] pos_next;

  // stage 1 moves on when the result slot is free or being emptied
  assign s1_fire    = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || s1_fire;

  always_comb begin
    b = in_q.in_byte;

    // first_byte restarts parsing before this byte is looked at
    if (in_q.first_byte) begin
      pos_b   = '0;
      crc_b   = CrcInit;
      magic_b = 1'b1;
      off_b   = '0;
      cnt_b   = '0;
      scrc_b  = '0;
      phase_b = PH_HEADER;
    end else begin
      pos_b   = pos_q;
      crc_b   = crc_q;
      magic_b = magic_q;
      off_b   = off_q;
      cnt_b   = cnt_q;
      scrc_b  = scrc_q;
      phase_b = phase_q;
    end

    pos_d     = pos_b;
    crc_d     = crc_b;
    magic_d   = magic_b;
    off_d     = off_b;
    cnt_d     = cnt_b;
    scrc_d    = scrc_b;
    phase_d   = phase_b;
    res_valid = 1'b0;
    res       = '0;
    lane      = 2'(pos_b);   // default lane; each header field branch below sets it from its field start
    scrc_fin  = '0;
    verdict   = VERDICT_OK;
    pos_next  = {1'b0, pos_b} + 33'd1;

    case (phase_b)
      PH_HEADER: begin
        if (pos_b < 32'(MagicLen) && b != magic_byte(2'(pos_b))) begin
          magic_d = 1'b0;
        end
        if (pos_b < 32'(CrcLen)) begin
          crc_d = crc_byte(crc_b, b);
        end
        if (pos_b >= 32'(OffsetPos) && pos_b < 32'(CountPos)) begin
          lane = 2'(pos_b - 32'(OffsetPos));
          off_d[{lane, 3'b000} +: 8] = off_b[{lane, 3'b000} +: 8] | b;
        end else if (pos_b >= 32'(CountPos) && pos_b < 32'(StoredCrcPos)) begin
          lane = 2'(pos_b - 32'(CountPos));
          cnt_d[{lane, 3'b000} +: 8] = cnt_b[{lane, 3'b000} +: 8] | b;
        end else if (pos_b >= 32'(StoredCrcPos) && pos_b < 32'(HeaderBytes)) begin
          lane = 2'(pos_b - 32'(StoredCrcPos));
          scrc_d[{lane, 3'b000} +: 8] = scrc_b[{lane, 3'b000} +: 8] | b;
        end
        pos_d = pos_next[31:0];

        if (pos_b == 32'(HeaderBytes - 1)) begin
          // last header byte: the stored CRC is complete only in scrc_d
          scrc_fin = scrc_d;
          if (!magic_b) begin
            verdict = VERDICT_BAD_MAGIC;
          end else if (~crc_b != scrc_fin) begin
            verdict = VERDICT_BAD_CRC;
          end else if (off_b < 32'(HeaderBytes)) begin
            verdict = VERDICT_UNDERFLOW;
          end else begin
            verdict = VERDICT_OK;
          end
          // offset equal to header length: ok, but nothing to pass through
          if (verdict == VERDICT_OK && off_b > 32'(HeaderBytes)) begin
            phase_d = PH_PAYLOAD;
          end else begin
            phase_d = PH_DROP;
          end
          res_valid          = 1'b1;
          res.item_kind      = KIND_VERDICT;
          res.verdict        = verdict;
          res.index_position = off_b;
          res.entry_count    = cnt_b;
        end
      end
      PH_PAYLOAD: begin
        pos_d          = pos_next[31:0];
        res_valid      = 1'b1;
        res.item_kind  = KIND_PAYLOAD;
        res.plain_byte = rotate_right(b);
        if (pos_next >= {1'b0, off_b}) begin
          res.payload_end = 1'b1;
          phase_d         = PH_DROP;
        end
      end
      default: begin
        // drop phase (and the unused code): no result, position frozen
      end
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= CrcInit;
      magic_q <= 1'b1;
      off_q   <= '0;
      cnt_q   <= '0;
      scrc_q  <= '0;
      phase_q <= PH_HEADER;
    end else if (s1_fire) begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      magic_q <= magic_d;
      off_q   <= off_d;
      cnt_q   <= cnt_d;
      scrc_q  <= scrc_d;
      phase_q <= phase_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_fire) begin
      out_v_q <= res_valid;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/ahcd_checker.sv
// ----------------------------------------------------------------------------
// ahcd_checker: port-level checks for the header check block
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module ahcd_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input ahcd_pkg::in_t   in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input ahcd_pkg::out_t  out_data_o
);
  import ahcd_pkg::*;

  // no beat offered while in reset; the flops settle by the edge after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("out_valid_o high during reset");

  // an empty output side never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("in_ready_o low with no output pending");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // unused fields are zero for each kind of beat
  a_fields_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.item_kind == KIND_VERDICT && out_data_o.plain_byte == 8'd0 &&
        !out_data_o.payload_end) ||
       (out_data_o.item_kind == KIND_PAYLOAD && out_data_o.verdict == VERDICT_OK &&
        out_data_o.index_position == 32'd0 && out_data_o.entry_count == 32'd0)))
    else $error("unused output fields not zero");

endmodule

bind archive_header_check_and_descramble_top ahcd_checker u_ahcd_checker (.*);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: archive header check and descramble, self-checking
// Streams archives byte by byte into the block: well-formed headers with
// random payloads, broken magic, broken CRC, short offsets, cut headers and
// noise. A parser model tracks the accepted bytes and predicts each verdict
// and payload beat; the output beats are checked in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import ahcd_pkg::*;

  localparam int DrainCycles = 20;    // a few times the two-stage latency
  localparam int StallLimit  = 2000;  // cycles without any beat moving
  localparam int TargetBytes = 1950;  // header and payload bytes to send

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  archive_header_check_and_descramble_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus store and prediction store.
  in_t  stream_bytes[$];
  out_t predicted_beats[$];

  int total_beats    = 0;
  int useful_beats   = 0;   // header and payload bytes, not dropped ones
  int archives_built = 0;
  int beats_sent     = 0;   // driver's own count
  int beats_in       = 0;   // monitor's own count
  int fault_count    = 0;
  int idle_cycles    = 0;
  int payload_seen   = 0;
  int payload_ends   = 0;
  int verdict_seen[4] = '{default: 0};

  // Parser state as the model keeps it.
  logic [31:0] arch_pos;
  logic [31:0] crc_reg;
  logic        magic_ok;
  logic [31:0] held_offset;
  logic [31:0] held_count;
  logic [31:0] held_crc;
  phase_e      parse_phase;

  // Reflected CRC-32, one data bit at a time, LSB first.
  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  // Idle percentages per stage: sender-light, then receiver-light, then none.
  function automatic int idle_pct(input int done, input bit sender);
    if (done < total_beats / 3) return sender ? 14 : 76;
    if (done < 2 * total_beats / 3) return sender ? 76 : 14;
    return 0;
  endfunction

  task automatic restart_parser();
    arch_pos    = '0;
    crc_reg     = CrcInit;
    magic_ok    = 1'b1;
    held_offset = '0;
    held_count  = '0;
    held_crc    = '0;
    parse_phase = PH_HEADER;
  endtask

  // Advance the parser by one accepted byte and queue what it should emit.
  task automatic parse_archive_byte(input in_t beat);
    logic [7:0]  b;
    logic [7:0]  magic_want;
    logic [31:0] pos;
    verdict_e    v;
    out_t        res;
    b   = beat.in_byte;
    res = '0;
    if (beat.first_byte) restart_parser();
    case (parse_phase)
      PH_HEADER: begin
        pos = arch_pos;
        if (pos < MagicLen) begin
          case (pos)
            32'd0:   magic_want = MagicByte0;
            32'd1:   magic_want = MagicByte1;
            default: magic_want = MagicByte2;
          endcase
          if (b != magic_want) magic_ok = 1'b0;
        end
        if (pos < CrcLen) crc_reg = crc32_update(crc_reg, b);
        if (pos >= OffsetPos && pos < CountPos)
          held_offset[8 * (pos - OffsetPos) +: 8] = b;
        else if (pos >= CountPos && pos < StoredCrcPos)
          held_count[8 * (pos - CountPos) +: 8] = b;
        else if (pos >= StoredCrcPos && pos < HeaderBytes)
          held_crc[8 * (pos - StoredCrcPos) +: 8] = b;
        arch_pos = pos + 32'd1;
        if (pos == HeaderBytes - 1) begin
          // magic beats CRC beats a short offset
          if (!magic_ok)                  v = VERDICT_BAD_MAGIC;
          else if (~crc_reg != held_crc)  v = VERDICT_BAD_CRC;
          else if (held_offset < HeaderBytes) v = VERDICT_UNDERFLOW;
          else                            v = VERDICT_OK;
          parse_phase = (v == VERDICT_OK && held_offset > HeaderBytes) ? PH_PAYLOAD : PH_DROP;
          res.item_kind      = KIND_VERDICT;
          res.verdict        = v;
          res.index_position = held_offset;
          res.entry_count    = held_count;
          predicted_beats.push_back(res);
        end
      end
      PH_PAYLOAD: begin
        pos = arch_pos;
        arch_pos = pos + 32'd1;
        res.item_kind  = KIND_PAYLOAD;
        res.plain_byte = (b >> RotateBits) | (b << (8 - RotateBits));
        if (pos + 32'd1 >= held_offset) begin
          res.payload_end = 1'b1;
          parse_phase     = PH_DROP;
        end
        predicted_beats.push_back(res);
      end
      default: ;  // drop phase: nothing out, position frozen
    endcase
  endtask

  // Queue one archive: header (optionally cut short or corrupted) then `body`
  // random bytes, which are payload and/or index bytes depending on offset.
  task automatic add_archive(input bit restart, input logic [31:0] offset,
                             input logic [31:0] count, input int bad_magic_at,
                             input bit bad_crc, input int cut, input int body);
    logic [7:0]  hdr[HeaderBytes];
    logic [31:0] crc;
    int          hdr_len;
    int          i;
    hdr[0] = MagicByte0;
    hdr[1] = MagicByte1;
    hdr[2] = MagicByte2;
    for (i = MagicLen; i < OffsetPos; i++) hdr[i] = 8'($urandom);
    for (i = 0; i < 4; i++) begin
      hdr[OffsetPos + i] = offset[8 * i +: 8];
      hdr[CountPos + i]  = count[8 * i +: 8];
    end
    if (bad_magic_at >= 0) hdr[bad_magic_at] ^= 8'($urandom_range(1, 255));
    crc = CrcInit;
    for (i = 0; i < CrcLen; i++) crc = crc32_update(crc, hdr[i]);
    crc = ~crc;
    if (bad_crc) crc[$urandom_range(31)] ^= 1'b1;
    for (i = 0; i < 4; i++) hdr[StoredCrcPos + i] = crc[8 * i +: 8];
    hdr_len = (cut >= 0 && cut < HeaderBytes) ? cut : HeaderBytes;
    for (i = 0; i < hdr_len; i++)
      stream_bytes.push_back(in_t'{in_byte: hdr[i], first_byte: restart && i == 0});
    for (i = 0; i < body; i++)
      stream_bytes.push_back(in_t'{in_byte: 8'($urandom), first_byte: 1'b0});
    useful_beats += hdr_len;
    if (hdr_len == HeaderBytes && bad_magic_at < 0 && !bad_crc && offset > HeaderBytes)
      useful_beats += (offset - HeaderBytes < body) ? int'(offset - HeaderBytes) : body;
    archives_built++;
  endtask

  // Driver: a new beat may be loaded when the slot is empty or just taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (stream_bytes.size() != 0 && $urandom_range(99) >= idle_pct(beats_sent, 1'b1)) begin
        in_data  <= stream_bytes.pop_front();
        in_valid <= 1'b1;
        beats_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on input beats, then check output beats, in one process
  // so the prediction for a beat is always queued before it can be checked.
  always @(posedge clk_i) begin : monitor
    out_t want;
    logic bad;
    if (!rst_ni) begin
      restart_parser();
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_archive_byte(in_data);
        beats_in++;
      end
      if (out_valid && out_ready) begin
        if (predicted_beats.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected beat: kind=%0d verdict=%0d idx=%h cnt=%h byte=%h end=%0d",
                     out_data.item_kind, out_data.verdict, out_data.index_position,
                     out_data.entry_count, out_data.plain_byte, out_data.payload_end);
        end else begin
          want = predicted_beats.pop_front();
          bad  = (out_data.item_kind !== want.item_kind) ||
                 (out_data.verdict !== want.verdict) ||
                 (out_data.index_position !== want.index_position) ||
                 (out_data.entry_count !== want.entry_count) ||
                 (out_data.plain_byte !== want.plain_byte) ||
                 (out_data.payload_end !== want.payload_end);
          if (bad) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"mismatch: exp kind=%0d verdict=%0d idx=%h cnt=%h byte=%h end=%0d",
                        " | got kind=%0d verdict=%0d idx=%h cnt=%h byte=%h end=%0d"},
                       want.item_kind, want.verdict, want.index_position,
                       want.entry_count, want.plain_byte, want.payload_end,
                       out_data.item_kind, out_data.verdict, out_data.index_position,
                       out_data.entry_count, out_data.plain_byte, out_data.payload_end);
          end
          if (want.item_kind == KIND_VERDICT) begin
            verdict_seen[want.verdict]++;
          end else begin
            payload_seen++;
            if (want.payload_end) payload_ends++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct(beats_in, 1'b0));
    end
  end

  // Watchdog: any accepted beat on either side resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("timeout: no beat moved for %0d cycles", StallLimit);
        $display("testbench: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int          pick;
    int          len;
    int          i;
    logic [31:0] offs;

    // Directed archives.
    add_archive(1'b0, 32'd20, 32'd0, -1, 1'b0, -1, 3);         // no restart after reset
    add_archive(1'b1, 32'd18, 32'hFFFF_FFFF, -1, 1'b0, -1, 2); // offset at header end
    add_archive(1'b1, 32'd40, 32'd5, 0, 1'b0, -1, 3);          // bad first magic byte
    add_archive(1'b1, 32'd40, 32'd5, 1, 1'b1, -1, 2);          // magic wins over CRC
    add_archive(1'b1, 32'd40, 32'd5, 2, 1'b0, -1, 0);
    add_archive(1'b1, 32'd25, 32'd7, -1, 1'b1, -1, 4);         // bad CRC, rest dropped
    add_archive(1'b1, 32'd3, 32'd7, -1, 1'b1, -1, 0);          // CRC wins over short offset
    add_archive(1'b1, 32'd0, 32'd0, -1, 1'b0, -1, 2);          // offset zero
    add_archive(1'b1, 32'd17, 32'd1, -1, 1'b0, -1, 0);         // offset one short
    add_archive(1'b1, 32'd19, 32'd2, -1, 1'b0, -1, 1);         // single payload byte
    add_archive(1'b1, 32'hFFFF_FFFF, 32'h8000_0001, -1, 1'b0, -1, 6); // cut by restart
    add_archive(1'b1, 32'd30, 32'd3, -1, 1'b0, 7, 0);          // header cut mid-offset
    add_archive(1'b1, 32'd20, 32'd9, -1, 1'b0, -1, 2);
    add_archive(1'b0, 32'd22, 32'd9, -1, 1'b0, -1, 4);         // no restart: all dropped
    add_archive(1'b1, 32'd30, 32'hA5A5_5A5A, -1, 1'b0, -1, 12);

    // Random archives, mostly well formed.
    while (useful_beats < TargetBytes) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        case ($urandom_range(19))
          0:       offs = HeaderBytes;
          1, 2:    offs = HeaderBytes + $urandom_range(41, 300);
          default: offs = HeaderBytes + $urandom_range(1, 40);
        endcase
        add_archive($urandom_range(19) != 0, offs, $urandom, -1, 1'b0, -1,
                    offs - HeaderBytes + $urandom_range(0, 3));
      end else if (pick < 68) begin
        // huge offset, payload cut short by the next restart
        add_archive(1'b1, {1'b1, 31'($urandom)}, $urandom, -1, 1'b0, -1,
                    $urandom_range(1, 20));
      end else if (pick < 76) begin
        add_archive(1'b1, $urandom, $urandom, $urandom_range(0, 2), 1'($urandom), -1,
                    $urandom_range(0, 4));
      end else if (pick < 84) begin
        offs = $urandom_range(1) ? $urandom : $urandom_range(0, 60);
        add_archive(1'b1, offs, $urandom, -1, 1'b1, -1, $urandom_range(0, 4));
      end else if (pick < 90) begin
        add_archive(1'b1, $urandom_range(0, HeaderBytes - 1), $urandom, -1, 1'b0, -1,
                    $urandom_range(0, 3));
      end else if (pick < 95) begin
        add_archive(1'b1, $urandom, $urandom, -1, 1'b0, $urandom_range(1, HeaderBytes - 1), 0);
      end else begin
        // noise with the odd stray restart
        len = $urandom_range(1, 30);
        for (i = 0; i < len; i++)
          stream_bytes.push_back(in_t'{in_byte: 8'($urandom),
                                       first_byte: $urandom_range(7) == 0});
      end
    end
    total_beats = stream_bytes.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_in < total_beats || predicted_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (predicted_beats.size() != 0) begin
      fault_count += predicted_beats.size();
      $display("%0d predicted beats never arrived", predicted_beats.size());
    end

    $display("covered %0d archives in %0d byte beats; verdicts ok/magic/crc/short %0d/%0d/%0d/%0d",
             archives_built, beats_in, verdict_seen[VERDICT_OK], verdict_seen[VERDICT_BAD_MAGIC],
             verdict_seen[VERDICT_BAD_CRC], verdict_seen[VERDICT_UNDERFLOW]);
    $display("%0d payload bytes checked, %0d ending at the index; %0d faults",
             payload_seen, payload_ends, fault_count);
    if (fault_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ahcd_pkg.sv
hw/rtl/archive_header_check_and_descramble_top.sv
hw/rtl/ahcd_checker.sv
sim/testbench.sv
